@@ hdl/ssprk_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes, configuration type and constants for the SSP Runge-Kutta
// stage update pipeline. Has no dependencies; every other file imports it.
package ssprk_pkg;

  // Number of conserved variables that can carry a source term.
  localparam int MAX_VARS = 8;
  // Width that holds any variable count up to sixteen.
  localparam int HC_W = 5;

  // Configuration port geometry.
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  // Q16.16 word and the widths that the arithmetic grows to.
  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int DIV_W   = 35;  // sum of three face differences
  localparam int MAG_D_W = 34;  // magnitude of the divergence
  localparam int MAG_S_W = 32;  // magnitude of the source rate
  localparam int PD_W    = MAG_D_W + FRAC_W;
  localparam int PS_W    = MAG_S_W + FRAC_W;
  localparam int RD_W    = PD_W + 1;
  localparam int RS_W    = PS_W;
  localparam int U_W     = 53;  // signed update term
  localparam int N_W     = 55;  // signed stage numerator
  localparam int T_W     = 36;  // clamped rounded magnitude

  localparam logic [FRAC_W-1:0] RND_HALF = 16'h8000;

  // Divide by three through a scaled reciprocal, split in two partial products.
  localparam int RECIP_SHIFT = T_W;
  localparam logic [63:0] RECIP3 = (64'd1 << RECIP_SHIFT) / 64'd3;
  localparam int K_W  = 35;
  localparam int KL_W = 18;
  localparam int KH_W = K_W - KL_W;
  localparam logic [KL_W-1:0] RECIP3_LO = RECIP3[KL_W-1:0];
  localparam logic [KH_W-1:0] RECIP3_HI = RECIP3[K_W-1:KL_W];
  localparam int P_W  = T_W + K_W;
  localparam int QD_W = P_W - RECIP_SHIFT;
  localparam int QM_W = T_W;

  // Saturation rails.
  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Scheme codes.
  localparam logic [1:0] SCH_RK2  = 2'd0;
  localparam logic [1:0] SCH_SSP3 = 2'd1;
  localparam logic [1:0] SCH_FOUR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_SCHEME = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STAGE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIMS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HYDRO  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DTDX   = 3'd5;

  // Denominator of the stage rule.
  typedef enum logic [2:0] {
    DIV1,
    DIV2,
    DIV3,
    DIV4,
    DIV6
  } dsel_t;

  // Configuration registers as seen by the pipeline.
  typedef struct packed {
    logic [1:0]  scheme;
    logic [1:0]  stage;
    logic [1:0]  dims;
    logic [3:0]  hydro;
    logic [31:0] dt;
    logic [31:0] dtdx;
  } cfg_t;

  // Half the denominator, added before the division to round to nearest.
  function automatic logic [1:0] half_of(dsel_t d);
    logic [1:0] h;
    case (d)
      DIV2:    h = 2'd1;
      DIV3:    h = 2'd1;
      DIV4:    h = 2'd2;
      DIV6:    h = 2'd3;
      default: h = 2'd0;
    endcase
    return h;
  endfunction

endpackage

@@ hdl/ssprk_flux.sv @@
`timescale 1ns / 1ps
// Flux divergence and scaled update term, five register stages.
// Depends on ssprk_pkg for widths and the configuration type.
module ssprk_flux (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  ssprk_pkg::cfg_t                   cfg,
  input  logic                              in_valid,
  input  logic [2:0]                        var_index,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_x_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_x_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_y_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_y_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_z_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  flux_z_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  source_rate,
  input  logic signed [ssprk_pkg::Q_W-1:0]  q_current,
  input  logic signed [ssprk_pkg::Q_W-1:0]  q_saved,
  output logic                              u_valid,
  output logic signed [ssprk_pkg::U_W-1:0]  u,
  output logic signed [ssprk_pkg::Q_W-1:0]  u_q,
  output logic signed [ssprk_pkg::Q_W-1:0]  u_qs
);
  import ssprk_pkg::*;

  // Stage 1: divergence and source gating.
  logic signed [DIV_W-1:0] dx, dy, dz, div_nxt;
  logic [HC_W-1:0]         h_ext, h_eff;
  logic                    src_on;
  logic signed [Q_W-1:0]   src_nxt;
  logic                    s1_v_r;
  logic signed [DIV_W-1:0] s1_div_r;
  logic signed [Q_W-1:0]   s1_src_r, s1_q_r, s1_qs_r;

  always_comb begin
    dx = DIV_W'(flux_x_low) - DIV_W'(flux_x_high);
    dy = DIV_W'(flux_y_low) - DIV_W'(flux_y_high);
    dz = DIV_W'(flux_z_low) - DIV_W'(flux_z_high);
    div_nxt = dx;
    if (cfg.dims >= 2'd2) begin
      div_nxt = div_nxt + dy;
    end
    if (cfg.dims >= 2'd3) begin
      div_nxt = div_nxt + dz;
    end
    h_ext   = HC_W'(cfg.hydro);
    h_eff   = (h_ext > HC_W'(MAX_VARS)) ? HC_W'(MAX_VARS) : h_ext;
    src_on  = HC_W'(var_index) < h_eff;
    src_nxt = src_on ? source_rate : '0;
  end

  // Stage 2: magnitudes and signs for the unsigned multiplies.
  logic [MAG_D_W-1:0] md_nxt;
  logic [MAG_S_W-1:0] ms_nxt;
  logic               s2_v_r, s2_sd_r, s2_ss_r;
  logic [MAG_D_W-1:0] s2_md_r;
  logic [MAG_S_W-1:0] s2_ms_r;
  logic signed [Q_W-1:0] s2_q_r, s2_qs_r;

  always_comb begin
    md_nxt = s1_div_r[DIV_W-1] ? MAG_D_W'(-s1_div_r) : MAG_D_W'(s1_div_r);
    ms_nxt = s1_src_r[Q_W-1] ? MAG_S_W'(-s1_src_r) : MAG_S_W'(s1_src_r);
  end

  // Stage 3: partial products against the high and low register halves.
  logic [PD_W-1:0] pdh_nxt, pdl_nxt;
  logic [PS_W-1:0] psh_nxt, psl_nxt;
  logic            s3_v_r, s3_sd_r, s3_ss_r;
  logic [PD_W-1:0] s3_pdh_r, s3_pdl_r;
  logic [PS_W-1:0] s3_psh_r, s3_psl_r;
  logic signed [Q_W-1:0] s3_q_r, s3_qs_r;

  always_comb begin
    pdh_nxt = s2_md_r * cfg.dtdx[Q_W-1:FRAC_W];
    pdl_nxt = s2_md_r * cfg.dtdx[FRAC_W-1:0];
    psh_nxt = s2_ms_r * cfg.dt[Q_W-1:FRAC_W];
    psl_nxt = s2_ms_r * cfg.dt[FRAC_W-1:0];
  end

  // Stage 4: round the low products and add them to the high products.
  logic [RD_W-1:0] pdl_rnd, rd_nxt;
  logic [PS_W:0]   psl_rnd;
  logic [RS_W-1:0] rs_nxt;
  logic            s4_v_r, s4_sd_r, s4_ss_r;
  logic [RD_W-1:0] s4_rd_r;
  logic [RS_W-1:0] s4_rs_r;
  logic signed [Q_W-1:0] s4_q_r, s4_qs_r;

  always_comb begin
    pdl_rnd = RD_W'(s3_pdl_r) + RD_W'(RND_HALF);
    rd_nxt  = RD_W'(s3_pdh_r) + (pdl_rnd >> FRAC_W);
    psl_rnd = (PS_W + 1)'(s3_psl_r) + (PS_W + 1)'(RND_HALF);
    rs_nxt  = s3_psh_r + RS_W'(psl_rnd >> FRAC_W);
  end

  // Stage 5: restore signs and sum the two terms.
  logic signed [U_W-1:0] ud, us, u_nxt;
  logic                  s5_v_r;
  logic signed [U_W-1:0] s5_u_r;
  logic signed [Q_W-1:0] s5_q_r, s5_qs_r;

  always_comb begin
    ud    = s4_sd_r ? -signed'(U_W'(s4_rd_r)) : signed'(U_W'(s4_rd_r));
    us    = s4_ss_r ? -signed'(U_W'(s4_rs_r)) : signed'(U_W'(s4_rs_r));
    u_nxt = ud + us;
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // Payload registers advance with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_div_r <= div_nxt;
      s1_src_r <= src_nxt;
      s1_q_r   <= q_current;
      s1_qs_r  <= q_saved;
      s2_md_r  <= md_nxt;
      s2_ms_r  <= ms_nxt;
      s2_sd_r  <= s1_div_r[DIV_W-1];
      s2_ss_r  <= s1_src_r[Q_W-1];
      s2_q_r   <= s1_q_r;
      s2_qs_r  <= s1_qs_r;
      s3_pdh_r <= pdh_nxt;
      s3_pdl_r <= pdl_nxt;
      s3_psh_r <= psh_nxt;
      s3_psl_r <= psl_nxt;
      s3_sd_r  <= s2_sd_r;
      s3_ss_r  <= s2_ss_r;
      s3_q_r   <= s2_q_r;
      s3_qs_r  <= s2_qs_r;
      s4_rd_r  <= rd_nxt;
      s4_rs_r  <= rs_nxt;
      s4_sd_r  <= s3_sd_r;
      s4_ss_r  <= s3_ss_r;
      s4_q_r   <= s3_q_r;
      s4_qs_r  <= s3_qs_r;
      s5_u_r   <= u_nxt;
      s5_q_r   <= s4_q_r;
      s5_qs_r  <= s4_qs_r;
    end
  end

  assign u_valid = s5_v_r;
  assign u       = s5_u_r;
  assign u_q     = s5_q_r;
  assign u_qs    = s5_qs_r;

endmodule

@@ hdl/ssprk_comb.sv @@
`timescale 1ns / 1ps
// Stage rule selection: forms the exact numerator and picks the denominator.
// Depends on ssprk_pkg for widths, scheme codes and the denominator type.
module ssprk_comb (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  ssprk_pkg::cfg_t                   cfg,
  input  logic                              u_valid,
  input  logic signed [ssprk_pkg::U_W-1:0]  u,
  input  logic signed [ssprk_pkg::Q_W-1:0]  u_q,
  input  logic signed [ssprk_pkg::Q_W-1:0]  u_qs,
  output logic                              n_valid,
  output logic signed [ssprk_pkg::N_W-1:0]  n,
  output ssprk_pkg::dsel_t                  n_dsel,
  output logic                              n_bad,
  output logic signed [ssprk_pkg::Q_W-1:0]  n_q
);
  import ssprk_pkg::*;

  logic signed [N_W-1:0] qe, qse, ue, qu, n_nxt;
  dsel_t                 dsel_nxt;
  logic                  bad_nxt;
  logic                  s6_v_r, s6_bad_r;
  logic signed [N_W-1:0] s6_n_r;
  dsel_t                 s6_dsel_r;
  logic signed [Q_W-1:0] s6_q_r;

  // Numerator and denominator of the chosen stage rule.
  always_comb begin
    qe       = N_W'(u_q);
    qse      = N_W'(u_qs);
    ue       = N_W'(u);
    qu       = qe + ue;
    n_nxt    = qe;
    dsel_nxt = DIV1;
    bad_nxt  = 1'b0;
    case (cfg.scheme)
      SCH_RK2: begin
        if (cfg.stage == 2'd0) begin
          n_nxt = qu;
        end else if (cfg.stage == 2'd1) begin
          n_nxt    = qse + qu;
          dsel_nxt = DIV2;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      SCH_SSP3: begin
        if (cfg.stage == 2'd0) begin
          n_nxt = qu;
        end else if (cfg.stage == 2'd1) begin
          n_nxt    = (qse <<< 1) + qse + qu;
          dsel_nxt = DIV4;
        end else if (cfg.stage == 2'd2) begin
          n_nxt    = qse + (qu <<< 1);
          dsel_nxt = DIV3;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      SCH_FOUR: begin
        if (cfg.stage == 2'd2) begin
          n_nxt    = (qse <<< 2) + (qe <<< 1) + ue;
          dsel_nxt = DIV6;
        end else begin
          n_nxt    = (qe <<< 1) + ue;
          dsel_nxt = DIV2;
        end
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= u_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_n_r    <= n_nxt;
      s6_dsel_r <= dsel_nxt;
      s6_bad_r  <= bad_nxt;
      s6_q_r    <= u_q;
    end
  end

  assign n_valid = s6_v_r;
  assign n       = s6_n_r;
  assign n_dsel  = s6_dsel_r;
  assign n_bad   = s6_bad_r;
  assign n_q     = s6_q_r;

endmodule

@@ hdl/ssprk_rdiv.sv @@
`timescale 1ns / 1ps
// Rounded division by the stage denominator and saturation to Q16.16, five stages.
// Depends on ssprk_pkg for widths, the reciprocal constant and the denominator type.
module ssprk_rdiv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              n_valid,
  input  logic signed [ssprk_pkg::N_W-1:0]  n,
  input  ssprk_pkg::dsel_t                  n_dsel,
  input  logic                              n_bad,
  input  logic signed [ssprk_pkg::Q_W-1:0]  n_q,
  output logic                              out_valid,
  output logic [ssprk_pkg::Q_W-1:0]         out_q_new,
  output logic                              out_saturated,
  output logic                              out_bad_stage
);
  import ssprk_pkg::*;

  // Stage 7: magnitude plus half the denominator, clamped to a width that
  // still saturates for every denominator.
  logic [N_W-1:0] nm, t;
  logic [T_W-1:0] t_nxt;
  logic           s7_v_r, s7_neg_r, s7_bad_r;
  logic [T_W-1:0] s7_t_r;
  dsel_t          s7_dsel_r;
  logic signed [Q_W-1:0] s7_q_r;

  always_comb begin
    nm    = n[N_W-1] ? N_W'(-n) : N_W'(n);
    t     = nm + N_W'(half_of(n_dsel));
    t_nxt = (|t[N_W-1:T_W]) ? '1 : t[T_W-1:0];
  end

  // Stage 8: dividend for the divide by three, reciprocal partial products.
  logic [T_W-1:0]        x_nxt;
  logic [T_W+KH_W-1:0]   ph_nxt;
  logic [T_W+KL_W-1:0]   pl_nxt;
  logic                  s8_v_r, s8_neg_r, s8_bad_r;
  logic [T_W-1:0]        s8_t_r, s8_x_r;
  logic [T_W+KH_W-1:0]   s8_ph_r;
  logic [T_W+KL_W-1:0]   s8_pl_r;
  dsel_t                 s8_dsel_r;
  logic signed [Q_W-1:0] s8_q_r;

  always_comb begin
    x_nxt  = (s7_dsel_r == DIV6) ? (s7_t_r >> 1) : s7_t_r;
    ph_nxt = x_nxt * RECIP3_HI;
    pl_nxt = x_nxt * RECIP3_LO;
  end

  // Stage 9: quotient estimate, at most one below the true quotient.
  logic [P_W-1:0]        p;
  logic                  s9_v_r, s9_neg_r, s9_bad_r;
  logic [T_W-1:0]        s9_t_r, s9_x_r;
  logic [QD_W-1:0]       s9_q0_r;
  dsel_t                 s9_dsel_r;
  logic signed [Q_W-1:0] s9_q_r;

  always_comb begin
    p = (P_W'(s8_ph_r) << KL_W) + P_W'(s8_pl_r);
  end

  // Stage 10: correct the estimate and pick the quotient for the denominator.
  logic [T_W-1:0]        q0e, rem;
  logic [QM_W-1:0]       qd3, qm_nxt;
  logic                  s10_v_r, s10_neg_r, s10_bad_r;
  logic [QM_W-1:0]       s10_qm_r;
  logic signed [Q_W-1:0] s10_q_r;

  always_comb begin
    q0e = T_W'(s9_q0_r);
    rem = s9_x_r - ((q0e << 1) + q0e);
    qd3 = (rem >= T_W'(3)) ? (QM_W'(s9_q0_r) + QM_W'(1)) : QM_W'(s9_q0_r);
    case (s9_dsel_r)
      DIV1:    qm_nxt = s9_t_r;
      DIV2:    qm_nxt = s9_t_r >> 1;
      DIV4:    qm_nxt = s9_t_r >> 2;
      DIV3:    qm_nxt = qd3;
      DIV6:    qm_nxt = qd3;
      default: qm_nxt = s9_t_r;
    endcase
  end

  // Stage 11: sign, saturation and the pass-through of an invalid stage.
  logic [Q_W-1:0]  q_new_nxt;
  logic            sat_nxt;
  logic            out_valid_r, out_saturated_r, out_bad_stage_r;
  logic [Q_W-1:0]  out_q_new_r;

  always_comb begin
    q_new_nxt = Q_W'(s10_qm_r);
    sat_nxt   = 1'b0;
    if (s10_bad_r) begin
      q_new_nxt = s10_q_r;
    end else if (s10_neg_r) begin
      if (s10_qm_r > QM_W'(Q_MIN)) begin
        q_new_nxt = Q_MIN;
        sat_nxt   = 1'b1;
      end else begin
        q_new_nxt = Q_W'(-s10_qm_r);
      end
    end else if (s10_qm_r > QM_W'(Q_MAX)) begin
      q_new_nxt = Q_MAX;
      sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      s10_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s7_v_r      <= n_valid;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= s8_v_r;
      s10_v_r     <= s9_v_r;
      out_valid_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t_r          <= t_nxt;
      s7_neg_r        <= n[N_W-1];
      s7_dsel_r       <= n_dsel;
      s7_bad_r        <= n_bad;
      s7_q_r          <= n_q;
      s8_x_r          <= x_nxt;
      s8_ph_r         <= ph_nxt;
      s8_pl_r         <= pl_nxt;
      s8_t_r          <= s7_t_r;
      s8_neg_r        <= s7_neg_r;
      s8_dsel_r       <= s7_dsel_r;
      s8_bad_r        <= s7_bad_r;
      s8_q_r          <= s7_q_r;
      s9_q0_r         <= p[P_W-1:RECIP_SHIFT];
      s9_x_r          <= s8_x_r;
      s9_t_r          <= s8_t_r;
      s9_neg_r        <= s8_neg_r;
      s9_dsel_r       <= s8_dsel_r;
      s9_bad_r        <= s8_bad_r;
      s9_q_r          <= s8_q_r;
      s10_qm_r        <= qm_nxt;
      s10_neg_r       <= s9_neg_r;
      s10_bad_r       <= s9_bad_r;
      s10_q_r         <= s9_q_r;
      out_q_new_r     <= q_new_nxt;
      out_saturated_r <= sat_nxt;
      out_bad_stage_r <= s10_bad_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_q_new     = out_q_new_r;
  assign out_saturated = out_saturated_r;
  assign out_bad_stage = out_bad_stage_r;

`ifndef SYNTHESIS
  // A clipped result never comes with the invalid-stage flag.
  a_sat_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_saturated_r && out_bad_stage_r))
    else $error("saturated and bad_stage both set");

  // A clipped result sits on one of the two rails.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_saturated_r |-> (out_q_new_r == Q_MAX || out_q_new_r == Q_MIN))
    else $error("saturated result is not on a rail");
`endif

endmodule

@@ hdl/ssp_runge_kutta_stage_update.sv @@
`timescale 1ns / 1ps
// A result word reaches the out_ ports through the flux, stage rule and division
// registers. Throughput: one word per cycle; every stage advances together and
// the whole pipeline holds while the output word is stalled.
// Reset (synchronous, rst_n low) empties the pipeline and loads the registers with
// scheme 0, stage 0, one dimension, three hydro variables, zero step sizes.
module ssp_runge_kutta_stage_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssprk_pkg::ADDR_W-1:0]      paddr,
  input  logic [ssprk_pkg::DATA_W-1:0]      pwdata,
  output logic [ssprk_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_var_index,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_x_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_x_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_y_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_y_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_z_low,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_flux_z_high,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_source_rate,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_q_current,
  input  logic signed [ssprk_pkg::Q_W-1:0]  in_q_saved,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ssprk_pkg::Q_W-1:0]  out_q_new,
  output logic                              out_saturated,
  output logic                              out_bad_stage
);
  import ssprk_pkg::*;

  // Configuration registers.
  logic [1:0]  scheme_select_r, stage_index_r, dimension_count_r;
  logic [3:0]  hydro_var_count_r;
  logic [31:0] time_step_r, step_over_spacing_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic        wr_en;
  cfg_t        cfg;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_select_r     <= SCH_RK2;
      stage_index_r       <= 2'd0;
      dimension_count_r   <= 2'd1;
      hydro_var_count_r   <= 4'd3;
      time_step_r         <= '0;
      step_over_spacing_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SCHEME: scheme_select_r     <= pwdata[1:0];
        REG_STAGE:  stage_index_r       <= pwdata[1:0];
        REG_DIMS:   dimension_count_r   <= pwdata[1:0];
        REG_HYDRO:  hydro_var_count_r   <= pwdata[3:0];
        REG_DT:     time_step_r         <= pwdata;
        REG_DTDX:   step_over_spacing_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_SCHEME: prdata = DATA_W'(scheme_select_r);
      REG_STAGE:  prdata = DATA_W'(stage_index_r);
      REG_DIMS:   prdata = DATA_W'(dimension_count_r);
      REG_HYDRO:  prdata = DATA_W'(hydro_var_count_r);
      REG_DT:     prdata = time_step_r;
      REG_DTDX:   prdata = step_over_spacing_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{scheme: scheme_select_r, stage: stage_index_r, dims: dimension_count_r,
                 hydro: hydro_var_count_r, dt: time_step_r, dtdx: step_over_spacing_r};

  // The pipeline moves whenever the output word is not held.
  logic en;
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  logic                  u_valid;
  logic signed [U_W-1:0] u;
  logic signed [Q_W-1:0] u_q, u_qs;

  ssprk_flux u_flux (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .var_index   (in_var_index),
    .flux_x_low  (in_flux_x_low),
    .flux_x_high (in_flux_x_high),
    .flux_y_low  (in_flux_y_low),
    .flux_y_high (in_flux_y_high),
    .flux_z_low  (in_flux_z_low),
    .flux_z_high (in_flux_z_high),
    .source_rate (in_source_rate),
    .q_current   (in_q_current),
    .q_saved     (in_q_saved),
    .u_valid     (u_valid),
    .u           (u),
    .u_q         (u_q),
    .u_qs        (u_qs)
  );

  logic                  n_valid, n_bad;
  logic signed [N_W-1:0] n;
  dsel_t                 n_dsel;
  logic signed [Q_W-1:0] n_q;

  ssprk_comb u_comb (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg),
    .u_valid (u_valid),
    .u       (u),
    .u_q     (u_q),
    .u_qs    (u_qs),
    .n_valid (n_valid),
    .n       (n),
    .n_dsel  (n_dsel),
    .n_bad   (n_bad),
    .n_q     (n_q)
  );

  logic [Q_W-1:0] q_new_bits;

  ssprk_rdiv u_rdiv (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .n_valid       (n_valid),
    .n             (n),
    .n_dsel        (n_dsel),
    .n_bad         (n_bad),
    .n_q           (n_q),
    .out_valid     (out_valid),
    .out_q_new     (q_new_bits),
    .out_saturated (out_saturated),
    .out_bad_stage (out_bad_stage)
  );

  assign out_q_new = signed'(q_new_bits);

`ifndef SYNTHESIS
  // A result word that leaves frees the pipeline for a new input word.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while the output drains");
`endif

endmodule
